FILE: design/csbm_pkg.sv
// ----------------------------------------------------------------------------
// csbm_pkg: shared constants for the cosine similarity best match block
// Field widths, register reset values, register indexes and the epsilon
// floor of the similarity denominator.
// ----------------------------------------------------------------------------
package csbm_pkg;

    localparam int VAL_W  = 16;   // Q2.14 element, Q1.15 similarity
    localparam int SCAN_W = 11;
    localparam int POS_W  = 10;

    localparam logic [VAL_W-1:0]  THR_RESET  = 16'd13107;
    localparam logic [SCAN_W-1:0] SCAN_RESET = 11'd1024;

    // 0.001 in Q.28
    localparam logic [31:0] EPS_Q28 = 32'd268435;

    // register index, taken from paddr bit 2
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_SCAN_LIMIT = 1'b1;

    localparam logic CMD_ENTRY = 1'b0;

    typedef logic signed [VAL_W-1:0] t_val;

endpackage

FILE: design/csbm_ram.sv
// ----------------------------------------------------------------------------
// csbm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module csbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: design/cosine_similarity_best_match.sv
// The block accepts one element per cycle while idle; o_in_stall is raised otherwise.
// Entry commit: the assembly buffer is copied into the store.
// Query: the query norm first, then per scanned entry the dot product and
//   entry norm (NW = 31 + clog2(DIM) bits wide) on the shared multiplier,
//   shift-add multiply, bitwise square root and restoring divider.
// Reset (synchronous, active low) empties the store and the assembly buffer.
// ----------------------------------------------------------------------------
// cosine_similarity_best_match: bounded vector store with best-match search
// Stores vectors FIFO-style and scans queries for the entry with the
// greatest cosine similarity above a programmable threshold.
// ----------------------------------------------------------------------------
module cosine_similarity_best_match #(
    parameter int CAPACITY = 1024,
    parameter int DIM      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [15:0] i_element_value,
    input  logic        i_last_element,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [9:0]  o_match_position,
    output logic [15:0] o_best_similarity,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int PW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int ECW  = $clog2(DIM + 1);
    localparam int QAW  = DIM > 1 ? $clog2(DIM) : 1;
    localparam int EDEP = CAPACITY * DIM;
    localparam int EAW  = $clog2(EDEP);
    localparam int NW   = 31 + $clog2(DIM);
    localparam int IW   = $clog2(NW);
    localparam int LW   = CW > csbm_pkg::SCAN_W ? CW : csbm_pkg::SCAN_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_COPY   = 4'd1;
    localparam logic [3:0] ST_QNORM  = 4'd2;
    localparam logic [3:0] ST_BASE   = 4'd3;
    localparam logic [3:0] ST_DOT    = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_SQRT   = 4'd6;
    localparam logic [3:0] ST_DIVCHK = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_CMP    = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    localparam logic [PW:0]    CAP_X   = (PW+1)'(CAPACITY);
    localparam logic [CW-1:0]  CAP_C   = CW'(CAPACITY);
    localparam logic [EAW-1:0] DIM_E   = EAW'(DIM);
    localparam logic [ECW-1:0] DIM_LST = ECW'(DIM - 1);
    localparam logic [ECW-1:0] DIM_C   = ECW'(DIM);
    localparam logic [NW-1:0]  EPS_N   = NW'(csbm_pkg::EPS_Q28);

    logic [3:0]            r_state;
    logic [1:0]            r_phase;
    logic [ECW-1:0]        r_k;
    logic [ECW-1:0]        r_elem_cnt;
    logic [PW-1:0]         r_oldest;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_p;
    logic [CW-1:0]         r_lim;
    logic [EAW-1:0]        r_base;
    logic signed [31:0]    r_prod;
    logic signed [NW:0]    r_dot;
    logic [NW-1:0]         r_enorm;
    logic [NW-1:0]         r_qnorm;
    logic [2*NW-1:0]       r_acc;
    logic [NW-1:0]         r_mq;
    logic [IW-1:0]         r_it;
    logic [NW+1:0]         r_rem;
    logic [NW-1:0]         r_root;
    logic [NW+14:0]        r_drem;
    logic [NW+15:0]        r_dsh;
    logic [16:0]           r_q;
    logic                  r_sat;
    logic                  r_neg;
    csbm_pkg::t_val        r_best;
    logic [PW-1:0]         r_pos;
    logic                  r_found;
    csbm_pkg::t_val        r_thr;
    logic [csbm_pkg::SCAN_W-1:0] r_scan;
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [9:0]            r_out_pos;
    logic [15:0]           r_out_sim;

    logic                  in_acc;
    logic                  emit_go;
    logic                  q_we;
    logic [15:0]           q_rdata;
    logic [15:0]           e_rdata;
    logic                  e_we;
    logic [EAW-1:0]        e_addr;
    csbm_pkg::t_val        qv;
    csbm_pkg::t_val        ev;
    csbm_pkg::t_val        m_a;
    csbm_pkg::t_val        m_b;
    logic signed [31:0]    m_prod;
    logic [PW:0]           new_sum;
    logic [PW-1:0]         new_slot;
    logic [PW:0]           scan_sum;
    logic [PW-1:0]         scan_slot;
    logic [PW:0]           adv_sum;
    logic [PW-1:0]         adv_ptr;
    logic [LW-1:0]         lim_c;
    logic [NW+1:0]         sq_next;
    logic [NW+1:0]         sq_trial;
    logic [NW-1:0]         den_c;
    logic [NW:0]           dot_abs;
    logic [NW-1:0]         mag_c;
    logic [NW+15:0]        drem_x;
    logic signed [16:0]    sim_c;
    logic [PW+9:0]         pos_ext;
    logic                  cfg_wr;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign emit_go    = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign q_we       = in_acc && (r_elem_cnt < DIM_C);
    assign e_we       = (r_state == ST_COPY) && (r_phase == 2'd1);
    assign e_addr     = r_base + EAW'(r_k);

    csbm_ram #(.WIDTH(16), .DEPTH(DIM)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_elem_cnt[QAW-1:0]),
        .i_wdata (i_element_value),
        .i_raddr (r_k[QAW-1:0]),
        .o_rdata (q_rdata)
    );

    csbm_ram #(.WIDTH(16), .DEPTH(EDEP)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_addr),
        .i_wdata (qv),
        .i_raddr (e_addr),
        .o_rdata (e_rdata)
    );

    always_comb begin
        // elements past the fill count read as zero
        qv = (r_k < r_elem_cnt) ? csbm_pkg::t_val'(q_rdata) : '0;
        ev = csbm_pkg::t_val'(e_rdata);
        m_a = (r_state == ST_QNORM) ? qv : ev;
        m_b = (r_state == ST_DOT && r_phase == 2'd1) ? qv : m_a;
        m_prod = 32'(m_a) * 32'(m_b);

        new_sum  = (PW+1)'(r_oldest) + (PW+1)'(r_count);
        new_slot = (new_sum >= CAP_X) ? PW'(new_sum - CAP_X) : PW'(new_sum);
        if (r_count == CAP_C) begin
            new_slot = r_oldest;
        end
        scan_sum  = (PW+1)'(r_oldest) + (PW+1)'(r_p);
        scan_slot = (scan_sum >= CAP_X) ? PW'(scan_sum - CAP_X) : PW'(scan_sum);
        adv_sum   = (PW+1)'(r_oldest) + (PW+1)'(1);
        adv_ptr   = (adv_sum >= CAP_X) ? PW'(adv_sum - CAP_X) : PW'(adv_sum);

        lim_c = (LW'(r_scan) < LW'(r_count)) ? LW'(r_scan) : LW'(r_count);

        sq_next  = {r_rem[NW-1:0], r_acc[2*NW-1:2*NW-2]};
        sq_trial = {r_root, 2'b01};

        den_c   = (r_root < EPS_N) ? EPS_N : r_root;
        dot_abs = r_dot[NW] ? (NW+1)'(-r_dot) : (NW+1)'(r_dot);
        mag_c   = dot_abs[NW-1:0];
        drem_x  = (NW+16)'(r_drem);

        if (r_neg) begin
            sim_c = (r_sat || r_q > 17'd32768) ? -17'sd32768 : -$signed(r_q);
        end else begin
            sim_c = (r_sat || r_q > 17'd32767) ? 17'sd32767 : $signed(r_q);
        end

        pos_ext = (PW+10)'(r_pos);
    end

    // configuration port
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == csbm_pkg::REG_SCAN_LIMIT) ?
                      32'(r_scan) : {16'b0, r_thr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= csbm_pkg::THR_RESET;
            r_scan <= csbm_pkg::SCAN_RESET;
        end else if (cfg_wr) begin
            if (i_paddr[2] == csbm_pkg::REG_SCAN_LIMIT) begin
                r_scan <= i_pwdata[csbm_pkg::SCAN_W-1:0];
            end else begin
                r_thr <= i_pwdata[15:0];
            end
        end
    end

    // sequencer and shared datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 2'd0;
            r_elem_cnt  <= '0;
            r_oldest    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (r_elem_cnt < DIM_C) begin
                            r_elem_cnt <= r_elem_cnt + ECW'(1);
                        end
                        r_k     <= '0;
                        r_phase <= 2'd0;
                        if (i_last_element) begin
                            if (i_command == csbm_pkg::CMD_ENTRY) begin
                                r_base  <= EAW'(new_slot) * DIM_E;
                                r_state <= ST_COPY;
                            end else begin
                                r_lim   <= CW'(lim_c);
                                r_qnorm <= '0;
                                r_best  <= r_thr;
                                r_pos   <= '0;
                                r_found <= 1'b0;
                                r_p     <= '0;
                                r_state <= ST_QNORM;
                            end
                        end
                    end
                end
                ST_COPY: begin
                    if (r_phase == 2'd0) begin
                        r_phase <= 2'd1;
                    end else begin
                        r_phase <= 2'd0;
                        r_k     <= r_k + ECW'(1);
                        if (r_k == DIM_LST) begin
                            if (r_count == CAP_C) begin
                                r_oldest <= adv_ptr;
                            end else begin
                                r_count <= r_count + CW'(1);
                            end
                            r_elem_cnt <= '0;
                            r_state    <= ST_IDLE;
                        end
                    end
                end
                ST_QNORM: begin
                    case (r_phase)
                        2'd0: r_phase <= 2'd1;
                        2'd1: begin
                            r_prod  <= m_prod;
                            r_phase <= 2'd2;
                        end
                        default: begin
                            r_qnorm <= r_qnorm + NW'($unsigned(r_prod));
                            r_k     <= r_k + ECW'(1);
                            r_phase <= 2'd0;
                            if (r_k == DIM_LST) begin
                                r_state <= (r_lim == '0) ? ST_EMIT : ST_BASE;
                            end
                        end
                    endcase
                end
                ST_BASE: begin
                    r_base  <= EAW'(scan_slot) * DIM_E;
                    r_k     <= '0;
                    r_phase <= 2'd0;
                    r_dot   <= '0;
                    r_enorm <= '0;
                    r_state <= ST_DOT;
                end
                ST_DOT: begin
                    case (r_phase)
                        2'd0: r_phase <= 2'd1;
                        2'd1: begin
                            r_prod  <= m_prod;
                            r_phase <= 2'd2;
                        end
                        2'd2: begin
                            r_dot   <= r_dot + (NW+1)'(r_prod);
                            r_prod  <= m_prod;
                            r_phase <= 2'd3;
                        end
                        default: begin
                            r_enorm <= r_enorm + NW'($unsigned(r_prod));
                            r_k     <= r_k + ECW'(1);
                            r_phase <= 2'd0;
                            if (r_k == DIM_LST) begin
                                r_acc   <= '0;
                                r_mq    <= r_qnorm;
                                r_it    <= '0;
                                r_state <= ST_MUL;
                            end
                        end
                    endcase
                end
                ST_MUL: begin
                    // shift-add, query norm bits from the top
                    r_acc <= (r_acc << 1) + (r_mq[NW-1] ? (2*NW)'(r_enorm) : '0);
                    r_mq  <= r_mq << 1;
                    if (r_it == IW'(NW - 1)) begin
                        r_it    <= '0;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_it <= r_it + IW'(1);
                    end
                end
                ST_SQRT: begin
                    // one root bit per step
                    if (sq_next >= sq_trial) begin
                        r_rem  <= sq_next - sq_trial;
                        r_root <= {r_root[NW-2:0], 1'b1};
                    end else begin
                        r_rem  <= sq_next;
                        r_root <= {r_root[NW-2:0], 1'b0};
                    end
                    r_acc <= r_acc << 2;
                    r_it  <= r_it + IW'(1);
                    if (r_it == IW'(NW - 1)) begin
                        r_state <= ST_DIVCHK;
                    end
                end
                ST_DIVCHK: begin
                    // quotient at or above 2^17 saturates anyway
                    r_sat   <= (NW+2)'(mag_c) >= {den_c, 2'b00};
                    r_neg   <= r_dot[NW];
                    r_drem  <= {mag_c, 15'b0};
                    r_dsh   <= {den_c, 16'b0};
                    r_q     <= '0;
                    r_it    <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (drem_x >= r_dsh) begin
                        r_drem <= (NW+15)'(drem_x - r_dsh);
                        r_q    <= {r_q[15:0], 1'b1};
                    end else begin
                        r_q    <= {r_q[15:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_it  <= r_it + IW'(1);
                    if (r_it == IW'(16)) begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (sim_c > 17'(r_best)) begin
                        r_best  <= 16'(sim_c);
                        r_pos   <= PW'(r_p);
                        r_found <= 1'b1;
                    end
                    r_p     <= r_p + CW'(1);
                    r_state <= (r_p + CW'(1) == r_lim) ? ST_EMIT : ST_BASE;
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (emit_go) begin
                        r_out_found <= r_found;
                        r_out_pos   <= pos_ext[9:0];
                        r_out_sim   <= r_best;
                        r_elem_cnt  <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_found           = r_out_found;
    assign o_match_position  = r_out_pos;
    assign o_best_similarity = r_out_sim;

endmodule
